// File: rtl/core/skte_pkg.sv
// ----------------------------------------------------------------------------
// skte_pkg
// shared constants, codes, command/status types and key compare functions
// ----------------------------------------------------------------------------
`default_nettype none

package skte_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int KEY_BITS    = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int SRCH_W      = CNT_W + 1;
  localparam int STACK_PAIRS = 32;
  localparam int SP_W        = $clog2(STACK_PAIRS);
  localparam int TOP_W       = SP_W + 1;
  localparam int MODE_W      = 3;
  localparam int STAT_W      = 2;
  localparam int POS_W       = 10;
  localparam int OP_W        = 5;

  // request modes
  localparam logic [MODE_W-1:0] MODE_APPEND  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SORT    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_EXACT   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ATLEAST = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ    = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  // datapath operations
  localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD      = 5'd1;
  localparam logic [OP_W-1:0] OP_APPEND    = 5'd2;
  localparam logic [OP_W-1:0] OP_SORT_INIT = 5'd3;
  localparam logic [OP_W-1:0] OP_POS_RD    = 5'd4;
  localparam logic [OP_W-1:0] OP_POS_RES   = 5'd5;
  localparam logic [OP_W-1:0] OP_SRCH_RD   = 5'd6;
  localparam logic [OP_W-1:0] OP_SRCH_ST   = 5'd7;
  localparam logic [OP_W-1:0] OP_AL_RD     = 5'd8;
  localparam logic [OP_W-1:0] OP_AL_RES    = 5'd9;
  localparam logic [OP_W-1:0] OP_POP_RD    = 5'd10;
  localparam logic [OP_W-1:0] OP_POP       = 5'd11;
  localparam logic [OP_W-1:0] OP_PIV_RD    = 5'd12;
  localparam logic [OP_W-1:0] OP_PIV       = 5'd13;
  localparam logic [OP_W-1:0] OP_HI_RD     = 5'd14;
  localparam logic [OP_W-1:0] OP_HI_ST     = 5'd15;
  localparam logic [OP_W-1:0] OP_LO_RD     = 5'd16;
  localparam logic [OP_W-1:0] OP_LO_ST     = 5'd17;
  localparam logic [OP_W-1:0] OP_PIV_WR    = 5'd18;
  localparam logic [OP_W-1:0] OP_PUSH_A    = 5'd19;
  localparam logic [OP_W-1:0] OP_PUSH_B    = 5'd20;
  localparam logic [OP_W-1:0] OP_EMIT      = 5'd21;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } skte_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              fill_lt2;
    logic              top_zero;
    logic              range_ok;
    logic              p_lt;
    logic              p_ne;
    logic              gt_piv;
    logic              lt_piv;
    logic              s_empty;
    logic              s_gt;
    logic              s_lt;
    logic              out_free;
  } skte_stat_t;

  function automatic logic [KEY_BITS-1:0] key_bias(input logic [KEY_BITS-1:0] a,
                                                   input logic sgn);
    logic [KEY_BITS-1:0] m;
    m = {sgn, {(KEY_BITS-1){1'b0}}};
    return a ^ m;
  endfunction

  function automatic logic key_gt(input logic [KEY_BITS-1:0] a,
                                  input logic [KEY_BITS-1:0] b, input logic sgn);
    return key_bias(a, sgn) > key_bias(b, sgn);
  endfunction

  function automatic logic key_lt(input logic [KEY_BITS-1:0] a,
                                  input logic [KEY_BITS-1:0] b, input logic sgn);
    return key_bias(a, sgn) < key_bias(b, sgn);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/skte_ctrl.sv
// ----------------------------------------------------------------------------
// skte_ctrl
// request sequencer: dispatch, search probing, quicksort partition and stack
// ----------------------------------------------------------------------------
`default_nettype none

module skte_ctrl
  import skte_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire skte_stat_t st,
  output skte_cmd_t       cmd
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DISP    = 5'd1;
  localparam logic [4:0] S_POS     = 5'd2;
  localparam logic [4:0] S_SRCH    = 5'd3;
  localparam logic [4:0] S_SRCH_ST = 5'd4;
  localparam logic [4:0] S_AL_RES  = 5'd5;
  localparam logic [4:0] S_POP_RD  = 5'd6;
  localparam logic [4:0] S_POP     = 5'd7;
  localparam logic [4:0] S_PIV_RD  = 5'd8;
  localparam logic [4:0] S_PIV     = 5'd9;
  localparam logic [4:0] S_LOOP    = 5'd10;
  localparam logic [4:0] S_HI_RD   = 5'd11;
  localparam logic [4:0] S_HI_ST   = 5'd12;
  localparam logic [4:0] S_LO_RD   = 5'd13;
  localparam logic [4:0] S_LO_ST   = 5'd14;
  localparam logic [4:0] S_PUSH_A  = 5'd15;
  localparam logic [4:0] S_PUSH_B  = 5'd16;
  localparam logic [4:0] S_EMIT    = 5'd17;

  logic [4:0] state;
  logic [4:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (st.mode)
          MODE_APPEND: begin
            cmd.op     = OP_APPEND;
            state_next = S_EMIT;
          end
          MODE_SORT: begin
            cmd.op     = OP_SORT_INIT;
            state_next = st.fill_lt2 ? S_EMIT : S_POP_RD;
          end
          MODE_EXACT, MODE_ATLEAST: begin
            state_next = S_SRCH;
          end
          MODE_READ: begin
            cmd.op     = OP_POS_RD;
            state_next = S_POS;
          end
          default: begin
            state_next = S_EMIT;
          end
        endcase
      end
      S_POS: begin
        cmd.op     = OP_POS_RES;
        state_next = S_EMIT;
      end
      S_SRCH: begin
        if (st.s_empty) begin
          if (st.mode == MODE_ATLEAST) begin
            cmd.op     = OP_AL_RD;
            state_next = S_AL_RES;
          end else begin
            state_next = S_EMIT;
          end
        end else begin
          cmd.op     = OP_SRCH_RD;
          state_next = S_SRCH_ST;
        end
      end
      S_SRCH_ST: begin
        cmd.op     = OP_SRCH_ST;
        state_next = (st.s_gt || st.s_lt) ? S_SRCH : S_EMIT;
      end
      S_AL_RES: begin
        cmd.op     = OP_AL_RES;
        state_next = S_EMIT;
      end
      S_POP_RD: begin
        if (st.top_zero) begin
          state_next = S_EMIT;
        end else begin
          cmd.op     = OP_POP_RD;
          state_next = S_POP;
        end
      end
      S_POP: begin
        cmd.op     = OP_POP;
        state_next = S_PIV_RD;
      end
      S_PIV_RD: begin
        if (st.range_ok) begin
          cmd.op     = OP_PIV_RD;
          state_next = S_PIV;
        end else begin
          state_next = S_POP_RD;
        end
      end
      S_PIV: begin
        cmd.op     = OP_PIV;
        state_next = S_LOOP;
      end
      S_LOOP: begin
        if (st.p_lt) begin
          state_next = S_HI_RD;
        end else begin
          cmd.op     = OP_PIV_WR;
          state_next = S_PUSH_A;
        end
      end
      S_HI_RD: begin
        cmd.op     = OP_HI_RD;
        state_next = S_HI_ST;
      end
      S_HI_ST: begin
        cmd.op     = OP_HI_ST;
        state_next = (st.gt_piv && st.p_ne) ? S_HI_RD : S_LO_RD;
      end
      S_LO_RD: begin
        cmd.op     = OP_LO_RD;
        state_next = S_LO_ST;
      end
      S_LO_ST: begin
        cmd.op     = OP_LO_ST;
        state_next = (st.lt_piv && st.p_ne) ? S_LO_RD : S_LOOP;
      end
      S_PUSH_A: begin
        cmd.op     = OP_PUSH_A;
        state_next = S_PUSH_B;
      end
      S_PUSH_B: begin
        cmd.op     = OP_PUSH_B;
        state_next = S_POP_RD;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/skte_dp.sv
// ----------------------------------------------------------------------------
// skte_dp
// key store, range stack, index registers, compare logic and output register
// ----------------------------------------------------------------------------
`default_nettype none

module skte_dp
  import skte_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire skte_cmd_t           cmd,
  output skte_stat_t               st,
  input  wire logic                cfg_we,
  input  wire logic                cfg_data,
  input  wire logic [MODE_W-1:0]   mode,
  input  wire logic [KEY_BITS-1:0] key,
  input  wire logic [POS_W-1:0]    position,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STAT_W-1:0]        status,
  output logic [KEY_BITS-1:0]      found_key,
  output logic [POS_W-1:0]         found_position,
  output logic [CNT_W-1:0]         entry_count
);

  logic [KEY_BITS-1:0] key_mem [TABLE_DEPTH];
  logic [2*CNT_W-1:0]  stack_mem [STACK_PAIRS];

  logic                key_signed;
  logic [CNT_W-1:0]    fill_count;
  logic [MODE_W-1:0]   mode_q;
  logic [KEY_BITS-1:0] key_q;
  logic [POS_W-1:0]    pos_q;

  logic signed [SRCH_W-1:0] s_lo;
  logic signed [SRCH_W-1:0] s_hi;
  logic signed [SRCH_W-1:0] s_mid;
  logic [CNT_W-1:0]    p_lo;
  logic [CNT_W-1:0]    p_hi;
  logic [CNT_W-1:0]    r_lo;
  logic [CNT_W-1:0]    r_hi;
  logic [CNT_W-1:0]    p_mid;
  logic [KEY_BITS-1:0] pivot;
  logic [TOP_W-1:0]    top;

  logic [STAT_W-1:0]   res_status;
  logic [KEY_BITS-1:0] res_key;
  logic [POS_W-1:0]    res_pos;

  logic                key_re;
  logic [IDX_W-1:0]    key_ra;
  logic [KEY_BITS-1:0] key_rd;
  logic                key_we;
  logic [IDX_W-1:0]    key_wa;
  logic [KEY_BITS-1:0] key_wd;

  logic                stk_re;
  logic [2*CNT_W-1:0]  stk_rd;
  logic                stk_we;
  logic [SP_W-1:0]     stk_wa;
  logic [2*CNT_W-1:0]  stk_wd;

  logic [SRCH_W:0]     s_sum;
  logic [IDX_W-1:0]    mid_c;
  logic                left_big;
  logic                push_ok;
  logic                full;
  logic                pos_ok;
  logic                al_ok;

  assign s_sum    = {s_lo[SRCH_W-1], s_lo} + {s_hi[SRCH_W-1], s_hi};
  assign mid_c    = s_sum[IDX_W:1];
  assign left_big = (p_mid - r_lo) > (r_hi - p_mid);
  assign push_ok  = top < TOP_W'(STACK_PAIRS);
  assign full     = fill_count >= CNT_W'(TABLE_DEPTH);
  assign pos_ok   = CNT_W'(pos_q) < fill_count;
  assign al_ok    = $unsigned(s_lo) < SRCH_W'(fill_count);

  // status toward the sequencer
  always_comb begin
    st.mode     = mode_q;
    st.fill_lt2 = fill_count < CNT_W'(2);
    st.top_zero = (top == '0);
    st.range_ok = (r_lo < r_hi) && (r_hi < CNT_W'(TABLE_DEPTH));
    st.p_lt     = p_lo < p_hi;
    st.p_ne     = p_lo != p_hi;
    st.gt_piv   = key_gt(key_rd, pivot, key_signed);
    st.lt_piv   = key_lt(key_rd, pivot, key_signed);
    st.s_empty  = s_lo > s_hi;
    st.s_gt     = key_gt(key_rd, key_q, key_signed);
    st.s_lt     = key_lt(key_rd, key_q, key_signed);
    st.out_free = !out_valid || !out_stall;
  end

  // key store port control
  always_comb begin
    key_re = 1'b0;
    key_ra = p_lo[IDX_W-1:0];
    key_we = 1'b0;
    key_wa = p_lo[IDX_W-1:0];
    key_wd = pivot;
    case (cmd.op)
      OP_POS_RD: begin
        key_re = 1'b1;
        key_ra = IDX_W'(pos_q);
      end
      OP_PIV_RD, OP_LO_RD: begin
        key_re = 1'b1;
      end
      OP_HI_RD: begin
        key_re = 1'b1;
        key_ra = p_hi[IDX_W-1:0];
      end
      OP_SRCH_RD: begin
        key_re = 1'b1;
        key_ra = mid_c;
      end
      OP_AL_RD: begin
        key_re = 1'b1;
        key_ra = s_lo[IDX_W-1:0];
      end
      OP_APPEND: begin
        key_we = !full;
        key_wa = fill_count[IDX_W-1:0];
        key_wd = key_q;
      end
      OP_HI_ST: begin
        key_we = !(st.gt_piv && st.p_ne) && st.p_ne;
        key_wd = key_rd;
      end
      OP_LO_ST: begin
        key_we = !(st.lt_piv && st.p_ne) && st.p_ne;
        key_wa = p_hi[IDX_W-1:0];
        key_wd = key_rd;
      end
      OP_PIV_WR: begin
        key_we = 1'b1;
      end
      default: begin
        key_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    if (key_re) begin
      key_rd <= key_mem[key_ra];
    end
  end

  // range stack port control
  always_comb begin
    stk_re = (cmd.op == OP_POP_RD);
    stk_we = 1'b0;
    stk_wa = top[SP_W-1:0];
    stk_wd = {r_lo, r_hi};
    case (cmd.op)
      OP_SORT_INIT: begin
        stk_we = 1'b1;
        stk_wa = '0;
        stk_wd = {CNT_W'(0), fill_count - CNT_W'(1)};
      end
      OP_PUSH_A: begin
        stk_we = push_ok;
        stk_wd = left_big ? {r_lo, p_mid - CNT_W'(1)} : {p_mid + CNT_W'(1), r_hi};
      end
      OP_PUSH_B: begin
        stk_we = push_ok && (left_big ? (r_hi > p_mid) : (p_mid > r_lo));
        stk_wd = left_big ? {p_mid + CNT_W'(1), r_hi} : {r_lo, p_mid - CNT_W'(1)};
      end
      default: begin
        stk_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_wa] <= stk_wd;
    end
    if (stk_re) begin
      stk_rd <= stack_mem[SP_W'(top - TOP_W'(1))];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_signed <= 1'b0;
      fill_count <= '0;
      top        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        key_signed <= cfg_data;
      end
      if (cmd.op == OP_APPEND && !full) begin
        fill_count <= fill_count + CNT_W'(1);
      end
      case (cmd.op)
        OP_SORT_INIT: top <= TOP_W'(1);
        OP_POP:       top <= top - TOP_W'(1);
        OP_PUSH_A:    if (stk_we) top <= top + TOP_W'(1);
        OP_PUSH_B:    if (stk_we) top <= top + TOP_W'(1);
        default:      top <= top;
      endcase
      if (cmd.op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        mode_q     <= mode;
        key_q      <= key;
        pos_q      <= position;
        s_lo       <= '0;
        s_hi       <= SRCH_W'(fill_count) - SRCH_W'(1);
        res_status <= ST_MISS;
        res_key    <= '0;
        res_pos    <= '0;
      end
      OP_APPEND: begin
        res_status <= full ? ST_FULL : ST_OK;
        res_pos    <= full ? '0 : POS_W'(fill_count);
      end
      OP_SORT_INIT: begin
        res_status <= ST_OK;
      end
      OP_POS_RES: begin
        if (pos_ok) begin
          res_status <= ST_OK;
          res_key    <= key_rd;
          res_pos    <= pos_q;
        end
      end
      OP_SRCH_RD: begin
        s_mid <= SRCH_W'(mid_c);
      end
      OP_SRCH_ST: begin
        if (st.s_gt) begin
          s_hi <= s_mid - SRCH_W'(1);
        end else if (st.s_lt) begin
          s_lo <= s_mid + SRCH_W'(1);
        end else begin
          res_status <= ST_OK;
          res_key    <= key_rd;
          res_pos    <= POS_W'(s_mid);
        end
      end
      OP_AL_RES: begin
        if (al_ok) begin
          res_status <= ST_OK;
          res_key    <= key_rd;
          res_pos    <= POS_W'(s_lo);
        end
      end
      OP_POP: begin
        r_lo <= stk_rd[2*CNT_W-1:CNT_W];
        r_hi <= stk_rd[CNT_W-1:0];
        p_lo <= stk_rd[2*CNT_W-1:CNT_W];
        p_hi <= stk_rd[CNT_W-1:0];
      end
      OP_PIV: begin
        pivot <= key_rd;
      end
      OP_HI_ST: begin
        if (st.gt_piv && st.p_ne) begin
          p_hi <= p_hi - CNT_W'(1);
        end else if (st.p_ne) begin
          p_lo <= p_lo + CNT_W'(1);
        end
      end
      OP_LO_ST: begin
        if (st.lt_piv && st.p_ne) begin
          p_lo <= p_lo + CNT_W'(1);
        end else if (st.p_ne) begin
          p_hi <= p_hi - CNT_W'(1);
        end
      end
      OP_PIV_WR: begin
        p_mid <= p_lo;
      end
      OP_EMIT: begin
        status         <= res_status;
        found_key      <= res_key;
        found_position <= res_pos;
        entry_count    <= fill_count;
      end
      default: begin
        pivot <= pivot;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/sorted_key_table_engine_core.sv
// ----------------------------------------------------------------------------
// sorted_key_table_engine_core
// table of up to 1024 keys with append, sort, exact and at-least search, read
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall) carries one request per transaction:
//   mode, key, position. output channel (out_valid / out_stall) returns one
//   result per request: status, found_key, found_position, entry_count.
//   cfg_we / cfg_data write key_signed (0 unsigned, 1 two's complement order);
//   the user writes it only while the block is idle; the block does not enforce it.
// timing
//   one request is in flight at a time; in_stall is high from acceptance until
//   the result is loaded into the output register. search is a binary search
//   that reads the single-port key store once per probe. sort is an in-place
//   quicksort partition over each range popped from the range stack, with the
//   first key of the range as pivot; it is slowest on already sorted data.
// reset
//   rst (synchronous) empties the table, clears key_signed and drops out_valid.
//   the key store itself is not cleared: only entries below the count are reported.
// backpressure
//   a held result stays on the output; the next request is still accepted and
//   worked on, and waits only at its own result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table_engine_core
  import skte_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // configuration
  input  wire logic                cfg_we,
  input  wire logic                cfg_data,
  // request channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [MODE_W-1:0]   mode,
  input  wire logic [KEY_BITS-1:0] key,
  input  wire logic [POS_W-1:0]    position,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STAT_W-1:0]        status,
  output logic [KEY_BITS-1:0]      found_key,
  output logic [POS_W-1:0]         found_position,
  output logic [CNT_W-1:0]         entry_count
);

  skte_cmd_t  cmd;   // per-cycle datapath operation
  skte_stat_t st;    // compare flags and mode back to the sequencer

  // sequencer: dispatch, binary search probing, quicksort partition loop
  skte_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // key store, range stack, index registers and output register
  skte_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .mode           (mode),
    .key            (key),
    .position       (position),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .found_key      (found_key),
    .found_position (found_position),
    .entry_count    (entry_count)
  );

endmodule

`default_nettype wire

// File: rtl/core/skte_checker.sv
// ----------------------------------------------------------------------------
// skte_checker
// port-level checks on the result channel and request flow control
// ----------------------------------------------------------------------------
`default_nettype none

module skte_checker
  import skte_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [STAT_W-1:0]   status,
  input wire logic [KEY_BITS-1:0] found_key,
  input wire logic [POS_W-1:0]    found_position,
  input wire logic [CNT_W-1:0]    entry_count
);

  // one request at a time: accepting a transaction closes the input
  a_accept_closes: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while another is in flight");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |->
      entry_count == CNT_W'(TABLE_DEPTH) && found_position == '0 && found_key == '0)
    else $error("full status with inconsistent fields");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_MISS |-> found_key == '0 && found_position == '0)
    else $error("miss status with nonzero fields");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count <= CNT_W'(TABLE_DEPTH) && status != 2'd3)
    else $error("result count or status out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(found_key)
      && $stable(found_position) && $stable(entry_count))
    else $error("stalled result changed");

endmodule

bind sorted_key_table_engine_core skte_checker u_skte_checker (.*);

`default_nettype wire
